// ----- design/rvx_pkg.sv -----
// Package for the RV32I subset execute stage: command codes, opcodes and helpers.
// Depends on nothing; the top level and the register file import it.
package rvx_pkg;

  typedef enum logic [4:0] {
    CMD_ADD, CMD_SUB, CMD_AND, CMD_OR, CMD_XOR, CMD_SLL, CMD_SRL, CMD_SRA,
    CMD_ADDI, CMD_ANDI, CMD_ORI, CMD_XORI, CMD_SLLI, CMD_SRLI, CMD_SRAI,
    CMD_LW, CMD_JALR, CMD_SW, CMD_BEQ, CMD_BNE, CMD_BGE, CMD_BLT, CMD_JAL, CMD_EXIT
  } cmd_t;

  typedef enum logic [2:0] {
    ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_XOR, ALU_SLL, ALU_SRL, ALU_SRA
  } alu_op_t;

  localparam logic [6:0]  OPC_REG   = 7'b0110011;
  localparam logic [6:0]  OPC_IMM   = 7'b0010011;
  localparam logic [6:0]  OPC_LOAD  = 7'b0000011;
  localparam logic [6:0]  OPC_JALR  = 7'b1100111;
  localparam logic [6:0]  OPC_STORE = 7'b0100011;
  localparam logic [6:0]  OPC_BR    = 7'b1100011;
  localparam logic [6:0]  OPC_JAL   = 7'b1101111;
  localparam logic [6:0]  ALT_F7    = 7'b0100000;
  localparam logic [11:0] SRAI_MARK = 12'b010000000000;
  localparam logic [31:0] EXIT_WORD = 32'hFFFF_FFFF;
  localparam logic [31:0] START_PC_RESET = 32'd1000;

  // funct3 of each ALU operation.
  function automatic logic [2:0] alu_f3(input alu_op_t op);
    logic [2:0] f;
    case (op)
      ALU_ADD, ALU_SUB: f = 3'd0;
      ALU_AND:          f = 3'd7;
      ALU_OR:           f = 3'd6;
      ALU_XOR:          f = 3'd4;
      ALU_SLL:          f = 3'd1;
      default:          f = 3'd5;
    endcase
    return f;
  endfunction

  // funct3 of beq, bne, bge, blt.
  function automatic logic [2:0] br_f3(input logic [1:0] k);
    logic [2:0] f;
    case (k)
      2'd0:    f = 3'd0;
      2'd1:    f = 3'd1;
      2'd2:    f = 3'd5;
      default: f = 3'd4;
    endcase
    return f;
  endfunction

  // Register file contents after reset: x1..x6 hold their own index.
  function automatic logic [31:0] reg_reset_val(input logic [4:0] idx);
    return (idx >= 5'd1 && idx <= 5'd6) ? {27'd0, idx} : 32'd0;
  endfunction

  // Standard 32-bit encoding of one instruction.
  function automatic logic [31:0] encode(input cmd_t cmd, input logic [4:0] rd,
                                         input logic [4:0] rs1, input logic [4:0] rs2,
                                         input logic [20:0] imm);
    logic [31:0] w;
    alu_op_t     op;
    logic [11:0] f;
    logic [6:0]  f7;
    w  = 32'd0;
    op = ALU_ADD;
    f  = imm[11:0];
    f7 = 7'd0;
    case (cmd) inside
      [CMD_ADD:CMD_SRA]: begin
        op = alu_op_t'(cmd[2:0]);
        f7 = (cmd == CMD_SUB || cmd == CMD_SRA) ? ALT_F7 : 7'd0;
        w  = {f7, rs2, rs1, alu_f3(op), rd, OPC_REG};
      end
      [CMD_ADDI:CMD_SRAI]: begin
        op = (cmd == CMD_ADDI) ? ALU_ADD : alu_op_t'(3'(cmd - 5'd7));
        if (op == ALU_SLL || op == ALU_SRL || op == ALU_SRA) begin
          f = {7'd0, imm[4:0]} | ((op == ALU_SRA) ? SRAI_MARK : 12'd0);
        end
        w = {f, rs1, alu_f3(op), rd, OPC_IMM};
      end
      CMD_LW:   w = {imm[11:0], rs1, 3'd2, rd, OPC_LOAD};
      CMD_JALR: w = {imm[11:0], rs1, 3'd0, rd, OPC_JALR};
      CMD_SW:   w = {imm[11:5], rs2, rs1, 3'd2, imm[4:0], OPC_STORE};
      [CMD_BEQ:CMD_BLT]: begin
        w = {imm[12], imm[10:5], rs2, rs1, br_f3(2'(cmd - 5'd18)), imm[4:1], imm[11], OPC_BR};
      end
      CMD_JAL:  w = {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
      CMD_EXIT: w = EXIT_WORD;
      default:  w = 32'd0;
    endcase
    return w;
  endfunction

endpackage

// ----- design/rvx_if.sv -----
// Handshake interfaces for the instruction items and the result items.
// Standalone; no package needed.
interface rvx_in_if;
  logic               valid;
  logic               ready;
  logic [4:0]         command;
  logic [4:0]         dest_reg;
  logic [4:0]         src1_reg;
  logic [4:0]         src2_reg;
  logic signed [20:0] immediate;
  modport source (output valid, command, dest_reg, src1_reg, src2_reg, immediate,
                  input ready);
  modport sink   (input valid, command, dest_reg, src1_reg, src2_reg, immediate,
                  output ready);
endinterface

interface rvx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] trace_pc;
  logic [31:0] next_pc;
  logic [31:0] machine_word;
  logic        halted;
  modport source (output valid, trace_pc, next_pc, machine_word, halted, input ready);
  modport sink   (input valid, trace_pc, next_pc, machine_word, halted, output ready);
endinterface

// ----- design/rv32i_subset_execute_encode.sv -----
// Top level: RV32I subset execute stage with encoder, register file and data memory.
// Uses rvx_pkg, rvx_in_if, rvx_out_if and rvx_regfile.
// Pipeline: an accepted item is held in stage 1, then in stage 2, which drives the
// result port. Throughput: one item per cycle while the result port is ready; the
// single data memory port takes one access per item.
// Reset: the data memory is cleared one word a cycle, from word 0 upward, with no item
// taken meanwhile; the pc returns to 1000 and the register file to its reset contents.
module rv32i_subset_execute_encode #(
  parameter int MEM_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  rvx_in_if.sink      in_ch,
  rvx_out_if.source   out_ch,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import rvx_pkg::*;

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  // Pipeline: stage 1 holds the item while the register file read data is
  // present; stage 2 holds the result and, for loads, the memory read data.
  logic              s1_valid_r;
  cmd_t              s1_cmd_r;
  logic [4:0]        s1_rd_r, s1_rs1_r, s1_rs2_r;
  logic [20:0]       s1_imm_r;

  logic              s2_valid_r;
  logic [31:0]       s2_pc_r, s2_next_r, s2_word_r, s2_val_r;
  logic              s2_halt_r, s2_wb_r, s2_load_r;
  logic [4:0]        s2_rd_r;

  // The last write into the register file, for items whose read raced it.
  logic              w_valid_r;
  logic [4:0]        w_idx_r;
  logic [31:0]       w_data_r;

  logic [31:0]       pc_r;
  logic              clr_busy_r;
  logic [AW-1:0]     clr_idx_r;
  logic [31:0]       dmem [MEM_WORDS];
  logic [31:0]       dmem_q_r;

  logic [31:0] rf_a, rf_b, a, b, s2_wdata;
  logic        adv, accept, rf_we;

  assign adv         = !s2_valid_r || out_ch.ready;
  assign in_ch.ready = !clr_busy_r && (!s1_valid_r || adv);
  assign accept      = in_ch.valid && in_ch.ready;
  assign s2_wdata    = s2_load_r ? dmem_q_r : s2_val_r;
  assign rf_we       = s2_valid_r && out_ch.ready && s2_wb_r;

  rvx_regfile u_rf (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr1 (in_ch.src1_reg),
    .rd_addr2 (in_ch.src2_reg),
    .rd_data1 (rf_a),
    .rd_data2 (rf_b),
    .wr_en    (rf_we),
    .wr_addr  (s2_rd_r),
    .wr_data  (s2_wdata)
  );

  // Operand forwarding: the result waiting in stage 2 wins over the last
  // completed write, which wins over the register file read data.
  always_comb begin
    a = rf_a;
    if (s2_valid_r && s2_wb_r && s2_rd_r == s1_rs1_r) begin
      a = s2_wdata;
    end else if (w_valid_r && w_idx_r == s1_rs1_r) begin
      a = w_data_r;
    end
    b = rf_b;
    if (s2_valid_r && s2_wb_r && s2_rd_r == s1_rs2_r) begin
      b = s2_wdata;
    end else if (w_valid_r && w_idx_r == s1_rs2_r) begin
      b = w_data_r;
    end
  end

  // Execute in stage 1.
  logic [31:0]   imm12, opb, alu_res, pc4, next_pc, ea, wb_val;
  alu_op_t       op;
  logic [4:0]    shamt;
  logic          wb_en, is_load, is_store, take, lt;
  logic [AW-1:0] maddr;

  always_comb begin
    imm12   = {{20{s1_imm_r[11]}}, s1_imm_r[11:0]};
    pc4     = pc_r + 32'd4;
    ea      = a + imm12;
    maddr   = AW'(ea % MEM_WORDS);
    lt      = $signed(a) < $signed(b);
    op      = ALU_ADD;
    opb     = b;
    wb_en   = 1'b0;
    is_load = 1'b0;
    is_store = 1'b0;
    take    = 1'b0;
    next_pc = pc4;
    if (s1_cmd_r inside {[CMD_ADDI:CMD_SRAI]}) begin
      op  = (s1_cmd_r == CMD_ADDI) ? ALU_ADD : alu_op_t'(3'(s1_cmd_r - 5'd7));
      opb = imm12;
    end else begin
      op  = alu_op_t'(s1_cmd_r[2:0]);
    end
    shamt = opb[4:0];
    case (op)
      ALU_ADD: alu_res = a + opb;
      ALU_SUB: alu_res = a - opb;
      ALU_AND: alu_res = a & opb;
      ALU_OR:  alu_res = a | opb;
      ALU_XOR: alu_res = a ^ opb;
      ALU_SLL: alu_res = a << shamt;
      ALU_SRL: alu_res = a >> shamt;
      default: alu_res = 32'($signed(a) >>> shamt);
    endcase
    wb_val = alu_res;
    case (s1_cmd_r) inside
      [CMD_ADD:CMD_SRAI]: wb_en = 1'b1;
      CMD_LW: begin
        wb_en   = 1'b1;
        is_load = 1'b1;
      end
      CMD_JALR: begin
        wb_en   = 1'b1;
        wb_val  = pc4;
        next_pc = ea & ~32'd1;
      end
      CMD_SW: is_store = 1'b1;
      [CMD_BEQ:CMD_BLT]: begin
        case (s1_cmd_r)
          CMD_BEQ: take = (a == b);
          CMD_BNE: take = (a != b);
          CMD_BGE: take = !lt;
          default: take = lt;
        endcase
        if (take) begin
          next_pc = pc_r + {{19{s1_imm_r[12]}}, s1_imm_r[12:1], 1'b0};
        end
      end
      CMD_JAL: begin
        wb_en   = 1'b1;
        wb_val  = pc4;
        next_pc = pc_r + {{11{s1_imm_r[20]}}, s1_imm_r[20:1], 1'b0};
      end
      default: next_pc = pc_r;
    endcase
    // Writes to x0 are dropped.
    wb_en = wb_en && (s1_rd_r != 5'd0);
  end

  // Data memory: a clearing pass after reset, then one access per advancing item.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      dmem[clr_idx_r] <= 32'd0;
    end else if (adv && s1_valid_r) begin
      if (is_store) begin
        dmem[maddr] <= b;
      end else begin
        dmem_q_r <= dmem[maddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + AW'(1);
      if (clr_idx_r == AW'(MEM_WORDS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      w_valid_r  <= 1'b0;
      pc_r       <= START_PC_RESET;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        s2_valid_r <= s1_valid_r;
      end
      if (rf_we) begin
        w_valid_r <= 1'b1;
      end
      if (cfg_wr_en) begin
        pc_r <= cfg_wr_data;
      end else if (adv && s1_valid_r) begin
        pc_r <= next_pc;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r <= cmd_t'(in_ch.command);
      s1_rd_r  <= in_ch.dest_reg;
      s1_rs1_r <= in_ch.src1_reg;
      s1_rs2_r <= in_ch.src2_reg;
      s1_imm_r <= in_ch.immediate;
    end
    if (adv && s1_valid_r) begin
      s2_pc_r   <= pc_r;
      s2_next_r <= next_pc;
      s2_word_r <= encode(s1_cmd_r, s1_rd_r, s1_rs1_r, s1_rs2_r, s1_imm_r);
      s2_halt_r <= (s1_cmd_r == CMD_EXIT);
      s2_wb_r   <= wb_en;
      s2_load_r <= is_load;
      s2_rd_r   <= s1_rd_r;
      s2_val_r  <= wb_val;
    end
    if (rf_we) begin
      w_idx_r  <= s2_rd_r;
      w_data_r <= s2_wdata;
    end
  end

  assign out_ch.valid        = s2_valid_r;
  assign out_ch.trace_pc     = s2_pc_r;
  assign out_ch.next_pc      = s2_next_r;
  assign out_ch.machine_word = s2_word_r;
  assign out_ch.halted       = s2_halt_r;
endmodule

// ----- design/rvx_regfile.sv -----
// Register file: 32 words, two registered read ports, one write port.
// Valid bits give the reset contents of entries never written. Uses rvx_pkg.
module rvx_regfile (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rd_en,
  input  logic [4:0]  rd_addr1,
  input  logic [4:0]  rd_addr2,
  output logic [31:0] rd_data1,
  output logic [31:0] rd_data2,
  input  logic        wr_en,
  input  logic [4:0]  wr_addr,
  input  logic [31:0] wr_data
);
  import rvx_pkg::*;

  logic [31:0] mem [32];
  logic [31:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data1 <= vld_r[rd_addr1] ? mem[rd_addr1] : reg_reset_val(rd_addr1);
      rd_data2 <= vld_r[rd_addr2] ? mem[rd_addr2] : reg_reset_val(rd_addr2);
    end
  end
endmodule

// ----- design/rvx_checker.sv -----
// Port-level checks for the execute stage, bound to the top level.
// Depends on rv32i_subset_execute_encode.
module rvx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_trace_pc,
  input logic [31:0] out_next_pc,
  input logic [31:0] out_word,
  input logic        out_halted,
  input logic        cfg_wr_en
);
  logic        seen_r;
  logic [31:0] last_next_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr_en) begin
      seen_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen_r      <= 1'b1;
      last_next_r <= out_next_pc;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_halted |-> out_word == 32'hFFFF_FFFF && out_next_pc == out_trace_pc)
    else $error("exit item with wrong word or pc");

  a_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_r |-> out_trace_pc == last_next_r)
    else $error("pc does not follow the previous item");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind rv32i_subset_execute_encode rvx_checker u_rvx_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_trace_pc (out_ch.trace_pc),
  .out_next_pc  (out_ch.next_pc),
  .out_word     (out_ch.machine_word),
  .out_halted   (out_ch.halted),
  .cfg_wr_en    (cfg_wr_en)
);

// ----- test/rvx_tb_if.sv -----
`timescale 1ns / 100ps
// Testbench-side view of the channel interfaces; the design files supply them.
// This file holds only the instruction and trace item types used by the test; depends on rvx_pkg.
package rvx_tb_pkg;
  import rvx_pkg::*;

  typedef struct packed {
    logic [4:0]  command;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [20:0] immediate;
  } instr_t;

  typedef struct packed {
    logic [31:0] trace_pc;
    logic [31:0] next_pc;
    logic [31:0] machine_word;
    logic        halted;
  } trace_t;
endpackage

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for rv32i_subset_execute_encode: drives decoded instructions, predicts
// pc, next pc, encoding and halt with a local execution model; uses rvx_pkg and rvx_if.
module testbench;
  import rvx_pkg::*;
  import rvx_tb_pkg::*;

  localparam int MEM_DEPTH = 1024;
  localparam int WATCH_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = 32'd0;

  rvx_in_if  in_ch ();
  rvx_out_if out_ch ();

  rv32i_subset_execute_encode #(.MEM_WORDS(MEM_DEPTH)) u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow architectural state used to predict each result item.
  logic [31:0] gpr [32];
  logic [31:0] dmem [MEM_DEPTH];
  logic [31:0] pc_now;
  trace_t      pending_traces [$];

  int  errors = 0;
  int  items_sent = 0;
  int  traces_seen = 0;
  int  idle_count = 0;
  bit  allow_idle = 1'b1;
  bit  cmd_seen [24];

  function automatic logic [31:0] sign_ext(input logic [31:0] v, input int bits);
    logic [31:0] m;
    m = (bits == 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
    v = v & m;
    if (v[bits-1]) begin
      v = v | ~m;
    end
    return v;
  endfunction

  task automatic reset_shadow(input logic [31:0] pc0);
    for (int i = 0; i < 32; i++) begin
      gpr[i] = (i >= 1 && i <= 6) ? 32'(i) : 32'd0;
    end
    for (int i = 0; i < MEM_DEPTH; i++) begin
      dmem[i] = 32'd0;
    end
    pc_now = pc0;
  endtask

  function automatic logic [31:0] alu_result(input logic [2:0] op, input logic [31:0] a,
                                             input logic [31:0] b);
    logic [31:0] r;
    case (alu_op_t'(op))
      ALU_ADD: r = a + b;
      ALU_SUB: r = a - b;
      ALU_AND: r = a & b;
      ALU_OR:  r = a | b;
      ALU_XOR: r = a ^ b;
      ALU_SLL: r = a << b[4:0];
      ALU_SRL: r = a >> b[4:0];
      default: r = $signed(a) >>> b[4:0];
    endcase
    return r;
  endfunction

  function automatic logic [2:0] funct3_of(input logic [2:0] op);
    case (alu_op_t'(op))
      ALU_ADD, ALU_SUB: return 3'd0;
      ALU_AND: return 3'd7;
      ALU_OR:  return 3'd6;
      ALU_XOR: return 3'd4;
      ALU_SLL: return 3'd1;
      default: return 3'd5;
    endcase
  endfunction

  task automatic write_gpr(input logic [4:0] idx, input logic [31:0] v);
    if (idx != 5'd0) begin
      gpr[idx] = v;
    end
  endtask

  // Executes one instruction on the shadow state and returns the expected trace.
  task automatic execute_instr(input instr_t it, output trace_t t);
    logic [31:0] a, b, imm21, imm12, next, word, off, f, addr;
    logic [2:0]  op;
    logic [1:0]  k;
    logic        take, lt;
    a = gpr[it.src1_reg];
    b = gpr[it.src2_reg];
    imm21 = sign_ext({11'd0, it.immediate}, 21);
    imm12 = sign_ext(imm21, 12);
    next = pc_now + 32'd4;
    word = 32'd0;
    t.halted = 1'b0;
    if (it.command <= CMD_SRA) begin
      op = it.command[2:0];
      write_gpr(it.dest_reg, alu_result(op, a, b));
      word = {(it.command == CMD_SUB || it.command == CMD_SRA) ? ALT_F7 : 7'd0,
              it.src2_reg, it.src1_reg, funct3_of(op), it.dest_reg, OPC_REG};
    end else if (it.command <= CMD_SRAI) begin
      op = (it.command == CMD_ADDI) ? 3'd0 : 3'(it.command - 5'd7);
      f = imm12;
      if (op >= 3'd5) begin
        f = {27'd0, imm12[4:0]} | ((op == 3'd7) ? {20'd0, SRAI_MARK} : 32'd0);
      end
      write_gpr(it.dest_reg, alu_result(op, a, imm12));
      word = {f[11:0], it.src1_reg, funct3_of(op), it.dest_reg, OPC_IMM};
    end else if (it.command == CMD_LW) begin
      addr = a + imm12;
      write_gpr(it.dest_reg, dmem[addr % MEM_DEPTH]);
      word = {imm12[11:0], it.src1_reg, 3'd2, it.dest_reg, OPC_LOAD};
    end else if (it.command == CMD_JALR) begin
      next = (a + imm12) & ~32'd1;
      write_gpr(it.dest_reg, pc_now + 32'd4);
      word = {imm12[11:0], it.src1_reg, 3'd0, it.dest_reg, OPC_JALR};
    end else if (it.command == CMD_SW) begin
      addr = a + imm12;
      dmem[addr % MEM_DEPTH] = b;
      word = {imm12[11:5], it.src2_reg, it.src1_reg, 3'd2, imm12[4:0], OPC_STORE};
    end else if (it.command <= CMD_BLT) begin
      off = sign_ext(imm21, 13) & ~32'd1;
      k = 2'(it.command - 5'd18);
      lt = $signed(a) < $signed(b);
      case (k)
        2'd0: take = (a == b);
        2'd1: take = (a != b);
        2'd2: take = !lt;
        default: take = lt;
      endcase
      if (take) begin
        next = pc_now + off;
      end
      word = {off[12], off[10:5], it.src2_reg, it.src1_reg,
              (k == 2'd0) ? 3'd0 : (k == 2'd1) ? 3'd1 : (k == 2'd2) ? 3'd5 : 3'd4,
              off[4:1], off[11], OPC_BR};
    end else if (it.command == CMD_JAL) begin
      off = imm21 & ~32'd1;
      write_gpr(it.dest_reg, pc_now + 32'd4);
      next = pc_now + off;
      word = {off[20], off[10:1], off[11], off[19:12], it.dest_reg, OPC_JAL};
    end else if (it.command == CMD_EXIT) begin
      next = pc_now;
      word = EXIT_WORD;
      t.halted = 1'b1;
    end else begin
      next = pc_now;
    end
    t.trace_pc = pc_now;
    t.next_pc = next;
    t.machine_word = word;
    pc_now = next;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("MISMATCH %s at result %0d: got %h, expected %h", what, traces_seen, got, want);
  endtask

  // Sends one instruction item, with an optional random idle burst in front.
  task automatic send_instr(input instr_t it);
    trace_t t;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= it.command;
    in_ch.dest_reg <= it.dest_reg;
    in_ch.src1_reg <= it.src1_reg;
    in_ch.src2_reg <= it.src2_reg;
    in_ch.immediate <= it.immediate;
    do @(posedge clk); while (!in_ch.ready);
    execute_instr(it, t);
    pending_traces.push_back(t);
    if (it.command < 24) begin
      cmd_seen[it.command] = 1'b1;
    end
    items_sent++;
  endtask

  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    while (pending_traces.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start_pc(input logic [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pc_now = v;
  endtask

  function automatic instr_t make_instr(input cmd_t c, input int rd, input int rs1,
                                        input int rs2, input int imm);
    instr_t it;
    it.command = c;
    it.dest_reg = 5'(rd);
    it.src1_reg = 5'(rs1);
    it.src2_reg = 5'(rs2);
    it.immediate = 21'(imm);
    return it;
  endfunction

  // Receiver: random stalls, compares every accepted result with the oldest prediction.
  always @(posedge clk) begin
    trace_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        traces_seen++;
        if (pending_traces.size() == 0) begin
          report_mismatch("unexpected result", out_ch.trace_pc, 32'd0);
        end else begin
          want = pending_traces.pop_front();
          if (out_ch.trace_pc !== want.trace_pc)
            report_mismatch("trace_pc", out_ch.trace_pc, want.trace_pc);
          if (out_ch.next_pc !== want.next_pc)
            report_mismatch("next_pc", out_ch.next_pc, want.next_pc);
          if (out_ch.machine_word !== want.machine_word)
            report_mismatch("machine_word", out_ch.machine_word, want.machine_word);
          if (out_ch.halted !== want.halted)
            report_mismatch("halted", {31'd0, out_ch.halted}, {31'd0, want.halted});
        end
      end
      if (!allow_idle) begin
        out_ch.ready <= 1'b1;
      end else if (idle_count > 0) begin
        idle_count <= idle_count - 1;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        idle_count <= $urandom_range(0, 6);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles with no accepted item on either channel and no start
  // pc write. The reset clearing pass of the data memory is covered by the limit too.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCH_LIMIT) begin
      $display("rv32i_subset_execute_encode verification failed");
      $finish;
    end
  end

  // Directed: field extremes, every command, x0 writes, an unused code.
  task automatic test_directed();
    send_instr(make_instr(CMD_ADD, 0, 1, 2, 0));        // write to x0 is dropped
    send_instr(make_instr(CMD_ADD, 7, 0, 6, 0));
    send_instr(make_instr(CMD_SUB, 31, 0, 6, 0));       // negative result
    send_instr(make_instr(CMD_AND, 8, 31, 5, 0));
    send_instr(make_instr(CMD_OR, 9, 4, 3, 0));
    send_instr(make_instr(CMD_XOR, 10, 31, 1, 0));
    send_instr(make_instr(CMD_SLL, 11, 31, 31, 0));     // shift by low 5 bits
    send_instr(make_instr(CMD_SRL, 12, 31, 4, 0));
    send_instr(make_instr(CMD_SRA, 13, 31, 4, 0));
    send_instr(make_instr(CMD_ADDI, 14, 1, 0, 2047));
    send_instr(make_instr(CMD_ANDI, 15, 31, 0, -2048));
    send_instr(make_instr(CMD_ORI, 16, 0, 0, -1));
    send_instr(make_instr(CMD_XORI, 17, 2, 0, 1048575)); // only low 12 bits count
    send_instr(make_instr(CMD_SLLI, 18, 6, 0, -1));
    send_instr(make_instr(CMD_SRLI, 19, 16, 0, 63));
    send_instr(make_instr(CMD_SRAI, 20, 16, 0, 31));
    send_instr(make_instr(CMD_SW, 0, 31, 31, -1));      // address wraps
    send_instr(make_instr(CMD_LW, 21, 31, 0, -1));
    send_instr(make_instr(CMD_JALR, 6, 6, 0, 1001));    // rd equals rs1, bit 0 cleared
    send_instr(make_instr(CMD_BEQ, 0, 0, 0, -1048576));
    send_instr(make_instr(CMD_BNE, 0, 1, 2, 4095));
    send_instr(make_instr(CMD_BGE, 0, 31, 1, 8));
    send_instr(make_instr(CMD_BLT, 0, 31, 1, -4096));
    send_instr(make_instr(CMD_JAL, 31, 0, 0, 1048575));
    send_instr(make_instr(CMD_EXIT, 5, 5, 5, 5));
    send_instr(make_instr(cmd_t'(5'd31), 31, 31, 31, -1)); // unused code
    send_instr(make_instr(CMD_ADD, 1, 1, 1, 0));         // runs on after exit
    drain_and_settle();
  endtask

  // Random: mostly valid commands with small register sets so values chain.
  task automatic test_random(input int count);
    instr_t it;
    int imm;
    for (int i = 0; i < count; i++) begin
      it.command = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(24, 31))
                                                : 5'($urandom_range(0, 23));
      it.dest_reg = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
      it.src1_reg = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
      it.src2_reg = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0: imm = $urandom_range(0, 64) - 32;
        1: imm = $urandom_range(0, 4095) - 2048;
        default: imm = int'($urandom_range(0, 2097151)) - 1048576;
      endcase
      it.immediate = 21'(imm);
      send_instr(it);
    end
    drain_and_settle();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = '0;
    in_ch.dest_reg = '0;
    in_ch.src1_reg = '0;
    in_ch.src2_reg = '0;
    in_ch.immediate = '0;
    reset_shadow(START_PC_RESET);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    write_start_pc(32'hFFFF_FFFC);   // pc wraps past the top
    test_random(150);
    write_start_pc(32'd0);
    test_random(150);
    write_start_pc($urandom);
    allow_idle = 1'b0;               // final stretch at full rate
    test_random(150);

    $display("Sent %0d instructions, checked %0d results; start pc set to low, high and random.",
             items_sent, traces_seen);
    foreach (cmd_seen[c]) begin
      if (!cmd_seen[c]) $display("Command %0d never issued.", c);
    end
    if (errors == 0 && pending_traces.size() == 0) begin
      $display("rv32i_subset_execute_encode verification clean");
    end else begin
      $display("rv32i_subset_execute_encode verification failed");
    end
    $finish;
  end
endmodule
